/* rtl/ntpm_pkg.sv */
// shared types and constants of the nearest timestamp pair matcher
`timescale 1ns / 1ps

package ntpm_pkg;

   localparam int STAMP_W  = 63;
   localparam int TAG_W    = 16;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam logic [CSR_W-1:0] MAX_OFFSET_RESET = 32'd10000000;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_INERTIAL = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_JOINT    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_MATCHED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_FAR = 2'd2;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [TAG_W-1:0]   tag;
   } ring_entry_type;

   typedef struct packed {
      logic           valid;
      ring_entry_type entry;
   } ring_push_type;

endpackage

/* rtl/ntpm_ring.sv */
// bounded ring of timestamped records held in a synchronous memory
`timescale 1ns / 1ps

module ntpm_ring #(
   parameter int QUEUE_DEPTH = ntpm_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ntpm_pkg::ring_push_type push,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_idx,
   output ntpm_pkg::ring_entry_type rd_entry,
   output logic [CNT_W-1:0]        count
);

   localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST    = IDX_W'(QUEUE_DEPTH - 1);

   ntpm_pkg::ring_entry_type mem [QUEUE_DEPTH];
   ntpm_pkg::ring_entry_type rd_entry_ff;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] wr_slot;
   logic             full;

   // physical slot of the k-th oldest record
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [IDX_W-1:0] k);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, k};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign full = (count_ff == DEPTH_C);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_slot  = slot_of(head_ff, count_ff[IDX_W-1:0]);
      if (full) begin
         // overwrite the oldest record
         wr_slot = head_ff;
      end
      if (push.valid) begin
         if (full) begin
            head_in = (head_ff == LAST) ? '0 : head_ff + IDX_W'(1);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_slot] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[slot_of(head_ff, rd_idx)];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign count    = count_ff;

endmodule

/* rtl/nearest_timestamp_pair_matcher_top.sv */
// top level of the nearest timestamp pair matcher: scan sequencer and result register
`timescale 1ns / 1ps

//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_func, req_stamp, req_tag
//  rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_inertial_tag,
//          |           |                     | rsp_joint_tag, rsp_offset_ns
//  csr     | in        | csr_wr_en           | csr_wr_data (max_offset_ns)
//
//  a record is stored as it is accepted; a tick with an empty queue goes to
//  S_DONE at once, any other reads every joint record against each inertial
//  record through the single joint read port, one pair per cycle in a pass
//  synchronous reset clears queue pointers, sequencer and result valid flag;
//  record memories and result data are not cleared
//  a result waits in the output register under rsp_stall; records are still
//  taken meanwhile, a following tick holds in its final state until the
//  register frees

module nearest_timestamp_pair_matcher_top #(
   parameter int QUEUE_DEPTH = ntpm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ntpm_pkg::FUNC_W-1:0]     req_func,
   input  logic [ntpm_pkg::STAMP_W-1:0]    req_stamp,
   input  logic [ntpm_pkg::TAG_W-1:0]      req_tag,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ntpm_pkg::STATUS_W-1:0]   rsp_status,
   output logic [ntpm_pkg::TAG_W-1:0]      rsp_inertial_tag,
   output logic [ntpm_pkg::TAG_W-1:0]      rsp_joint_tag,
   output logic [ntpm_pkg::STAMP_W-1:0]    rsp_offset_ns,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [ntpm_pkg::CSR_W-1:0]      csr_wr_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int STAMP_W = ntpm_pkg::STAMP_W;
   localparam int TAG_W   = ntpm_pkg::TAG_W;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOAD_I = 5'b00010,   // capture one inertial record, start joint reads
      S_SCAN   = 5'b00100,   // one joint read per cycle
      S_DRAIN  = 5'b01000,   // let the compare pipeline empty
      S_DONE   = 5'b10000    // hand the result to the output register
   } state_type;

   state_type state_ff, state_in;

   logic                   accept;
   ntpm_pkg::ring_push_type ipush, jpush;
   logic                   i_rd_en, j_rd_en;
   logic [IDX_W-1:0]       i_rd_idx, j_rd_idx;
   ntpm_pkg::ring_entry_type i_entry, j_entry;
   logic [CNT_W-1:0]       i_count, j_count;

   logic [ntpm_pkg::CSR_W-1:0] max_offset_ff;

   logic [IDX_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] jr_ff, jr_in;
   logic             i_last;
   logic             empty_ff, empty_in;

   // outer record held during one inner pass
   logic [STAMP_W-1:0] a_stamp_ff, a_stamp_in;
   logic [TAG_W-1:0]   a_tag_ff, a_tag_in;

   // pipeline: joint data valid, then difference stage
   logic               rd_valid_ff, rd_valid_in;
   logic               d_valid_ff;
   logic [STAMP_W-1:0] d_ff, d_in;
   logic [TAG_W-1:0]   d_itag_ff, d_jtag_ff;

   // running best pair
   logic               found_ff, found_in;
   logic [STAMP_W-1:0] best_ff, best_in;
   logic [TAG_W-1:0]   best_itag_ff, best_itag_in;
   logic [TAG_W-1:0]   best_jtag_ff, best_jtag_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ntpm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]              rsp_itag_ff, rsp_itag_in;
   logic [TAG_W-1:0]              rsp_jtag_ff, rsp_jtag_in;
   logic [STAMP_W-1:0]            rsp_offset_ff, rsp_offset_in;
   logic                          rsp_load;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   assign ipush.valid       = accept && (req_func == ntpm_pkg::FUNC_INERTIAL);
   assign ipush.entry.stamp = req_stamp;
   assign ipush.entry.tag   = req_tag;
   assign jpush.valid       = accept && (req_func == ntpm_pkg::FUNC_JOINT);
   assign jpush.entry.stamp = req_stamp;
   assign jpush.entry.tag   = req_tag;

   ntpm_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_inertial (
      .clock   (clock),
      .reset   (reset),
      .push    (ipush),
      .rd_en   (i_rd_en),
      .rd_idx  (i_rd_idx),
      .rd_entry(i_entry),
      .count   (i_count)
   );

   ntpm_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_joint (
      .clock   (clock),
      .reset   (reset),
      .push    (jpush),
      .rd_en   (j_rd_en),
      .rd_idx  (j_rd_idx),
      .rd_entry(j_entry),
      .count   (j_count)
   );

   assign i_last = ((CNT_W'(i_ff) + CNT_W'(1)) == i_count);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      jr_in       = jr_ff;
      empty_in    = empty_ff;
      a_stamp_in  = a_stamp_ff;
      a_tag_in    = a_tag_ff;
      i_rd_en     = 1'b0;
      i_rd_idx    = '0;
      j_rd_en     = 1'b0;
      j_rd_idx    = jr_ff[IDX_W-1:0];
      rd_valid_in = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_func == ntpm_pkg::FUNC_TICK) begin
               empty_in = (i_count == '0) || (j_count == '0);
               i_in     = '0;
               if ((i_count == '0) || (j_count == '0)) begin
                  state_in = S_DONE;
               end else begin
                  // oldest inertial record
                  i_rd_en  = 1'b1;
                  state_in = S_LOAD_I;
               end
            end
         end
         S_LOAD_I: begin
            a_stamp_in  = i_entry.stamp;
            a_tag_in    = i_entry.tag;
            j_rd_en     = 1'b1;
            j_rd_idx    = '0;
            rd_valid_in = 1'b1;
            jr_in       = CNT_W'(1);
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if (jr_ff < j_count) begin
               j_rd_en     = 1'b1;
               rd_valid_in = 1'b1;
               jr_in       = jr_ff + CNT_W'(1);
            end else if (!i_last) begin
               // next outer record; the last joint read still sees the old one
               i_rd_en  = 1'b1;
               i_rd_idx = i_ff + IDX_W'(1);
               i_in     = i_ff + IDX_W'(1);
               state_in = S_LOAD_I;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_valid_ff && !d_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // absolute difference stage
   always_comb begin
      if (a_stamp_ff >= j_entry.stamp) begin
         d_in = a_stamp_ff - j_entry.stamp;
      end else begin
         d_in = j_entry.stamp - a_stamp_ff;
      end
   end

   // best pair tracking, strict less keeps the first pair on ties
   always_comb begin
      found_in     = found_ff;
      best_in      = best_ff;
      best_itag_in = best_itag_ff;
      best_jtag_in = best_jtag_ff;
      if (state_ff == S_IDLE) begin
         found_in = 1'b0;
      end else if (d_valid_ff && (!found_ff || d_ff < best_ff)) begin
         found_in     = 1'b1;
         best_in      = d_ff;
         best_itag_in = d_itag_ff;
         best_jtag_in = d_jtag_ff;
      end
   end

   // result formation and output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_itag_in   = rsp_itag_ff;
      rsp_jtag_in   = rsp_jtag_ff;
      rsp_offset_in = rsp_offset_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (empty_ff) begin
            rsp_status_in = ntpm_pkg::STATUS_EMPTY;
            rsp_itag_in   = '0;
            rsp_jtag_in   = '0;
            rsp_offset_in = '0;
         end else if (best_ff > STAMP_W'(max_offset_ff)) begin
            rsp_status_in = ntpm_pkg::STATUS_TOO_FAR;
            rsp_itag_in   = '0;
            rsp_jtag_in   = '0;
            rsp_offset_in = best_ff;
         end else begin
            rsp_status_in = ntpm_pkg::STATUS_MATCHED;
            rsp_itag_in   = best_itag_ff;
            rsp_jtag_in   = best_jtag_ff;
            rsp_offset_in = best_ff;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_valid_ff   <= 1'b0;
         d_valid_ff    <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_offset_ff <= ntpm_pkg::MAX_OFFSET_RESET;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         d_valid_ff   <= rd_valid_ff;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_offset_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      jr_ff         <= jr_in;
      empty_ff      <= empty_in;
      a_stamp_ff    <= a_stamp_in;
      a_tag_ff      <= a_tag_in;
      d_ff          <= d_in;
      d_itag_ff     <= a_tag_ff;
      d_jtag_ff     <= j_entry.tag;
      best_ff       <= best_in;
      best_itag_ff  <= best_itag_in;
      best_jtag_ff  <= best_jtag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_itag_ff   <= rsp_itag_in;
      rsp_jtag_ff   <= rsp_jtag_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_inertial_tag = rsp_itag_ff;
   assign rsp_joint_tag    = rsp_jtag_ff;
   assign rsp_offset_ns    = rsp_offset_ff;

   // joint read data only arrives while a scan is running
   a_rd_valid_scope: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_SCAN || state_ff == S_LOAD_I || state_ff == S_DRAIN))
      else $error("joint read data outside of a scan");

   // the compare stage is empty before the result is formed
   a_d_valid_scope: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff |-> (state_ff == S_SCAN || state_ff == S_LOAD_I || state_ff == S_DRAIN))
      else $error("difference stage busy outside of a scan");

   // a scan only runs over two non-empty queues
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (i_count != '0 && j_count != '0 && !empty_ff))
      else $error("scan with an empty queue");

   // inner read counter stays within the joint queue
   a_jr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (jr_ff <= j_count))
      else $error("joint read counter beyond queue fill");

   // a non-empty result always has a compared pair behind it
   a_found_at_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !empty_ff) |-> found_ff)
      else $error("result formed without any compared pair");

endmodule

/* bench/nearest_timestamp_pair_matcher_top_test.sv */
// self-checking testbench of the nearest timestamp pair matcher with its own fuse predictor
`timescale 1ns / 1ps

module nearest_timestamp_pair_matcher_top_test;

   localparam int QUEUE_DEPTH = ntpm_pkg::QUEUE_DEPTH_DEFAULT;

   // func value with no meaning, must leave the queues alone and give no result
   localparam logic [ntpm_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

   localparam logic [ntpm_pkg::STAMP_W-1:0] STAMP_MAX = {ntpm_pkg::STAMP_W{1'b1}};
   localparam logic [ntpm_pkg::STAMP_W-1:0] FAR_STAMP = 63'h4000_0000_0000_0000;

   localparam int ST_INERTIAL = 0;
   localparam int ST_JOINT    = 1;

   localparam int unsigned ITEMS_PER_PHASE = 200;
   localparam int unsigned PHASE_COUNT     = 6;
   // long enough for a full 16 x 16 scan, with some margin
   localparam int unsigned SETTLE_CYCLES   = 320;
   // long receiver hold-off, long enough for two ticks to back up into req_stall
   localparam int unsigned HOLD_CYCLES     = 900;
   localparam longint      RUN_LIMIT_NS    = 64'd40_000_000;

   typedef logic [ntpm_pkg::STAMP_W-1:0] stamp_type;
   typedef logic [ntpm_pkg::TAG_W-1:0]   tag_type;
   typedef logic [ntpm_pkg::FUNC_W-1:0]  func_code_type;

   typedef struct packed {
      logic [ntpm_pkg::STATUS_W-1:0] status;
      tag_type                       inertial_tag;
      tag_type                       joint_tag;
      stamp_type                     offset_ns;
   } match_result_type;

   // two record rings, the threshold and the fuse results still owed by the block
   class pair_match_scoreboard;
      stamp_type                  rec_stamp [2][QUEUE_DEPTH];
      tag_type                    rec_tag   [2][QUEUE_DEPTH];
      int unsigned                head  [2];
      int unsigned                count [2];
      logic [ntpm_pkg::CSR_W-1:0] max_offset;
      match_result_type           expected_q [$];
      int unsigned                error_count;

      function new();
         head        = '{0, 0};
         count       = '{0, 0};
         max_offset  = ntpm_pkg::MAX_OFFSET_RESET;
         error_count = 0;
      endfunction

      // full ring: overwrite the oldest and move the head on
      function void store_record(int unsigned s, stamp_type st, tag_type tg);
         int unsigned slot;
         if (count[s] < QUEUE_DEPTH) begin
            slot = (head[s] + count[s]) % QUEUE_DEPTH;
            count[s]++;
         end else begin
            slot = head[s];
            head[s] = (head[s] + 1) % QUEUE_DEPTH;
         end
         rec_stamp[s][slot] = st;
         rec_tag[s][slot]   = tg;
      endfunction

      // inertial outer, joint inner, oldest first; strict less keeps the first tie
      function match_result_type nearest_pair();
         match_result_type r;
         stamp_type   a, b, d, best;
         bit          found;
         int unsigned i, j, pi, pj;
         tag_type     best_i, best_j;
         r      = '0;
         best   = '0;
         best_i = '0;
         best_j = '0;
         found  = 1'b0;
         if (count[ST_INERTIAL] == 0 || count[ST_JOINT] == 0) begin
            r.status = ntpm_pkg::STATUS_EMPTY;
            return r;
         end
         for (i = 0; i < count[ST_INERTIAL]; i++) begin
            pi = (head[ST_INERTIAL] + i) % QUEUE_DEPTH;
            a  = rec_stamp[ST_INERTIAL][pi];
            for (j = 0; j < count[ST_JOINT]; j++) begin
               pj = (head[ST_JOINT] + j) % QUEUE_DEPTH;
               b  = rec_stamp[ST_JOINT][pj];
               d  = (a >= b) ? a - b : b - a;
               if (!found || d < best) begin
                  found  = 1'b1;
                  best   = d;
                  best_i = rec_tag[ST_INERTIAL][pi];
                  best_j = rec_tag[ST_JOINT][pj];
               end
            end
         end
         r.offset_ns = best;
         if (best > stamp_type'(max_offset)) begin
            r.status = ntpm_pkg::STATUS_TOO_FAR;
         end else begin
            r.status       = ntpm_pkg::STATUS_MATCHED;
            r.inertial_tag = best_i;
            r.joint_tag    = best_j;
         end
         return r;
      endfunction

      function void note_request(func_code_type f, stamp_type st, tag_type tg);
         case (f)
            ntpm_pkg::FUNC_INERTIAL: store_record(ST_INERTIAL, st, tg);
            ntpm_pkg::FUNC_JOINT:    store_record(ST_JOINT, st, tg);
            ntpm_pkg::FUNC_TICK:     expected_q.insert(expected_q.size(), nearest_pair());
            default:                 ;
         endcase
      endfunction

      function void log_error(string what, match_result_type want, match_result_type got);
         error_count++;
         if (error_count <= 10)
            $display(
               "%0t ns: %s: status %0d/%0d itag %h/%h jtag %h/%h off %0d/%0d (exp/act)",
               $time, what, want.status, got.status, want.inertial_tag,
               got.inertial_tag, want.joint_tag, got.joint_tag,
               want.offset_ns, got.offset_ns);
      endfunction

      function void check_response(match_result_type got);
         match_result_type want;
         if (expected_q.size() == 0) begin
            log_error("fuse result with no tick waiting", '0, got);
            return;
         end
         want = expected_q[0];
         expected_q.delete(0);
         if (got.status !== want.status || got.inertial_tag !== want.inertial_tag ||
             got.joint_tag !== want.joint_tag || got.offset_ns !== want.offset_ns)
            log_error("fuse result mismatch", want, got);
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   func_code_type                 req_func;
   stamp_type                     req_stamp;
   tag_type                       req_tag;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [ntpm_pkg::STATUS_W-1:0] rsp_status;
   tag_type                       rsp_inertial_tag;
   tag_type                       rsp_joint_tag;
   stamp_type                     rsp_offset_ns;
   logic                          csr_wr_en;
   logic [ntpm_pkg::CSR_W-1:0]    csr_wr_data;

   pair_match_scoreboard sb;
   int unsigned          req_accepts = 0;  // request transactions seen so far
   bit                   idle_on;          // random gaps and stalls allowed
   int unsigned          hold_asks = 0;    // long hold-offs asked of the receiver

   nearest_timestamp_pair_matcher_top #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_stamp        (req_stamp),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_inertial_tag (rsp_inertial_tag),
      .rsp_joint_tag    (rsp_joint_tag),
      .rsp_offset_ns    (rsp_offset_ns),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // both channels sampled at the rising edge; the request is noted before the
   // response is checked, a same-edge result always belongs to an older tick
   always @(posedge clock) begin : watch_ports
      match_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_accepts++;
            sb.note_request(req_func, req_stamp, req_tag);
         end
         if (rsp_valid && !rsp_stall) begin
            got.status       = rsp_status;
            got.inertial_tag = rsp_inertial_tag;
            got.joint_tag    = rsp_joint_tag;
            got.offset_ns    = rsp_offset_ns;
            sb.check_response(got);
         end
      end
   end

   // receiver: random stall bursts with quiet stretches between,
   // plus one long hold-off on request, counted here in cycles
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned quiet_left;
      int unsigned holds_taken;
      logic        stall_next;
      rsp_stall   = 1'b0;
      stall_left  = 0;
      quiet_left  = 0;
      holds_taken = 0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_taken) begin
            holds_taken = hold_asks;
            stall_left  = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_next = 1'b1;
            stall_left--;
         end else if (quiet_left != 0) begin
            stall_next = 1'b0;
            quiet_left--;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_next = 1'b1;
            stall_left = $urandom_range(1, 18) - 1;
            quiet_left = $urandom_range(0, 60);
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   function automatic stamp_type rand_stamp();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ntpm_pkg::STAMP_W-1:0];
   endfunction

   // distance from the burst base, clustered on the threshold so that equal,
   // one over and one under all show up
   function automatic stamp_type near_offset();
      stamp_type t;
      t = stamp_type'(sb.max_offset);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return t;
         2:       return t + 1;
         3:       return (t == 0) ? t : t - 1;
         4:       return stamp_type'($urandom_range(0, sb.max_offset));
         default: return t + stamp_type'($urandom_range(0, sb.max_offset));
      endcase
   endfunction

   // one request transaction, with an optional random gap in front; the
   // payload holds until the monitor has seen the handshake
   task automatic offer(input func_code_type f, input stamp_type st, input tag_type tg);
      int unsigned seen;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      seen = req_accepts;
      req_valid <= 1'b1;
      req_func  <= f;
      req_stamp <= st;
      req_tag   <= tg;
      do @(negedge clock); while (req_accepts == seen);
   endtask

   // block idle: every result in and the longest scan has had time to finish
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [ntpm_pkg::CSR_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.max_offset = v;
   endtask

   // records of both kinds around one base time, then a tick; some stamps
   // repeat the previous one so that ties come up in both loop directions
   task automatic fuse_burst(inout int unsigned issued);
      stamp_type     base, prev, st, off;
      stamp_type     span;
      func_code_type f;
      int unsigned   n_rec, k;
      span = stamp_type'(1) << 34;
      base = rand_stamp();
      if (base < span)
         base = base + span;
      else if (base > STAMP_MAX - span)
         base = base - span;
      prev  = base;
      n_rec = ($urandom_range(0, 2) == 0) ? 2 : $urandom_range(2, 8);
      for (k = 0; k < n_rec; k++) begin
         if (k > 0 && $urandom_range(0, 5) == 0) begin
            st = prev;
         end else begin
            off = near_offset();
            st  = $urandom_range(0, 1) ? base + off : base - off;
         end
         // first one of each kind, so neither queue is empty at the tick
         if (k == 0)
            f = ntpm_pkg::FUNC_INERTIAL;
         else if (k == 1)
            f = ntpm_pkg::FUNC_JOINT;
         else
            f = $urandom_range(0, 1) ? ntpm_pkg::FUNC_JOINT : ntpm_pkg::FUNC_INERTIAL;
         offer(f, st, tag_type'($urandom));
         prev = st;
         issued++;
      end
      offer(ntpm_pkg::FUNC_TICK, rand_stamp(), tag_type'($urandom));
      issued++;
   endtask

   // any func value, stamps at the rails now and then
   task automatic noise_item(inout int unsigned issued);
      func_code_type f;
      stamp_type     st;
      f = func_code_type'($urandom_range(ntpm_pkg::FUNC_INERTIAL, FUNC_SPARE));
      case ($urandom_range(0, 7))
         0:       st = '0;
         1:       st = STAMP_MAX;
         default: st = rand_stamp();
      endcase
      offer(f, st, tag_type'($urandom));
      if (f != FUNC_SPARE)
         issued++;
   endtask

   initial begin : stimulus
      logic [ntpm_pkg::CSR_W-1:0] thresholds [PHASE_COUNT];
      int unsigned                issued;
      int unsigned                ph;
      int unsigned                k;
      sb           = new();
      idle_on      = 1'b1;
      req_valid    = 1'b0;
      req_func     = ntpm_pkg::FUNC_INERTIAL;
      req_stamp    = '0;
      req_tag      = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      reset        = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part under the reset threshold
      offer(ntpm_pkg::FUNC_TICK, '0, '0);                  // both queues empty
      offer(ntpm_pkg::FUNC_INERTIAL, '0, 16'hFFFF);
      offer(ntpm_pkg::FUNC_TICK, STAMP_MAX, 16'hFFFF);     // joint queue still empty
      offer(ntpm_pkg::FUNC_JOINT, STAMP_MAX, 16'h0000);
      offer(ntpm_pkg::FUNC_TICK, rand_stamp(), 16'h0000);  // too far, full-scale offset
      offer(FUNC_SPARE, rand_stamp(), 16'h5A5A);           // ignored
      offer(ntpm_pkg::FUNC_JOINT, 63'd5, 16'h1234);
      offer(ntpm_pkg::FUNC_INERTIAL, 63'd10, 16'hAAAA);
      offer(ntpm_pkg::FUNC_TICK, '0, '0);                  // tie, older inertial record wins
      // fill the inertial ring and wrap once: the stamp-zero record drops out
      for (k = 0; k < QUEUE_DEPTH - 1; k++)
         offer(ntpm_pkg::FUNC_INERTIAL, FAR_STAMP + k, tag_type'($urandom));
      offer(ntpm_pkg::FUNC_TICK, '0, '0);
      settle();

      // random phases, each under its own threshold, rails included
      thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom, ntpm_pkg::MAX_OFFSET_RESET,
                     $urandom_range(1, 5000)};
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         write_threshold(thresholds[ph]);
         if (ph == 2)
            hold_asks++;           // back the block up into req_stall
         if (ph == PHASE_COUNT - 1)
            idle_on = 1'b0;        // last stretch runs at full rate
         issued = 0;
         while (issued < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 3) != 0)
               fuse_burst(issued);
            else
               noise_item(issued);
         end
         settle();
      end

      if (sb.error_count == 0 && sb.expected_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
